/* rtl/hrf_pkg.sv */
`timescale 1ns / 1ps
// Shared types and constants for the HTTP response framer.
// Depends on nothing; used by http_response_framer.
package hrf_pkg;

   localparam int LENGTH_BITS = 32;

   typedef enum logic [3:0] {
      PH_VERSION, PH_CODE, PH_REASON, PH_KEY, PH_LEN, PH_SCAN, PH_SKIP,
      PH_BODY_LEN, PH_BODY_CLOSE, PH_CHUNK_SIZE, PH_CHUNK_DATA, PH_CHUNK_END,
      PH_TRAILER, PH_DONE, PH_FAILED
   } phase_type;

   typedef enum logic [1:0] {
      ACT_DATA = 2'd0, ACT_CLOSED = 2'd1, ACT_RESTART = 2'd2, ACT_NONE = 2'd3
   } action_type;

   typedef enum logic [2:0] {
      KIND_NOTHING = 3'd0, KIND_BODY = 3'd1, KIND_HEADER = 3'd2,
      KIND_COMPLETE = 3'd3, KIND_ERROR = 3'd4
   } kind_type;

   typedef enum logic [3:0] {
      ERR_NONE = 4'd0, ERR_STATUS_LINE = 4'd1, ERR_CODE = 4'd2, ERR_LENGTH = 4'd3,
      ERR_NO_FRAMING = 4'd4, ERR_CLOSED_HEADER = 4'd5, ERR_CHUNK_LINE = 4'd6,
      ERR_CHUNK_SIZE = 4'd7, ERR_MISSING_CRLF = 4'd8, ERR_CLOSED_BODY = 4'd9
   } err_type;

   // framing flag bits
   localparam int FL_LEN     = 0;
   localparam int FL_CHUNKED = 1;
   localparam int FL_CLOSE   = 2;
   localparam int FL_PEER    = 3;

   localparam logic [8*14-1:0] KEY_LEN_TEXT   = "content-length";
   localparam logic [8*17-1:0] KEY_TE_TEXT    = "transfer-encoding";
   localparam logic [8*10-1:0] KEY_CONN_TEXT  = "connection";
   localparam logic [8*7-1:0]  NEEDLE_CHUNKED = "chunked";
   localparam logic [8*5-1:0]  NEEDLE_CLOSE   = "close";

   localparam logic [4:0] KEY_LEN_SIZE  = 5'd14;
   localparam logic [4:0] KEY_TE_SIZE   = 5'd17;
   localparam logic [4:0] KEY_CONN_SIZE = 5'd10;

   // Character of key k at position pos, zero past the end of the key.
   function automatic logic [7:0] key_char(input logic [1:0] k, input logic [4:0] pos);
      logic [7:0] c;
      c = 8'h00;
      case (k)
         2'd0: if (pos < KEY_LEN_SIZE) c = KEY_LEN_TEXT[8*(13-int'(pos)) +: 8];
         2'd1: if (pos < KEY_TE_SIZE) c = KEY_TE_TEXT[8*(16-int'(pos)) +: 8];
         2'd2: if (pos < KEY_CONN_SIZE) c = KEY_CONN_TEXT[8*(9-int'(pos)) +: 8];
         default: c = 8'h00;
      endcase
      return c;
   endfunction

   // Character of the chunked/close needle at position pos.
   function automatic logic [7:0] needle_char(input logic chunk, input logic [2:0] pos);
      logic [7:0] c;
      c = 8'h00;
      if (chunk) begin
         if (pos < 3'd7) c = NEEDLE_CHUNKED[8*(6-int'(pos)) +: 8];
      end else begin
         if (pos < 3'd5) c = NEEDLE_CLOSE[8*(4-int'(pos)) +: 8];
      end
      return c;
   endfunction

   function automatic logic is_ws(input logic [7:0] b);
      return (b == 8'h20) || (b == 8'h09) || (b == 8'h0A) || (b == 8'h0B) || (b == 8'h0C);
   endfunction

   function automatic logic [7:0] lower(input logic [7:0] b);
      return (b >= 8'h41 && b <= 8'h5A) ? b + 8'd32 : b;
   endfunction

endpackage

/* rtl/http_response_framer.sv */
`timescale 1ns / 1ps
// HTTP/1.1 response framer: status/header parser and body framer.
// Depends on hrf_pkg.
//
// Usage:
//   req channel: one word per event; tuser holds the action (data byte,
//   peer closed, restart), tdata holds the received byte.
//   rsp channel: exactly one word per accepted req word, in order; tuser
//   holds the result kind, tdata the body byte, status code, close flag
//   and error code.
// Latency: a result is shown the cycle after its req word is accepted.
// Throughput: one word per cycle while rsp_tready stays high; the parser state advances on the
//   accepting edge and the result sits in a single output register, so the
//   next word is taken in the same cycle the pending result is taken.
// Stall: while rsp_tready is low and a result is held, req_tready drops;
//   nothing is lost or repeated.
// Reset: synchronous, active high; parser returns to waiting for a status
//   line and the output register empties. A restart action does the same
//   for the parser state and returns a nothing result.
// Content-Length and chunk sizes are held in hrf_pkg::LENGTH_BITS bits.
module http_response_framer (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] byte_value
   input  logic [1:0]  req_tuser,   // [1:0] action
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata,   // [7:0] body_byte, [17:8] status, [18] close_flag,
                                    // [22:19] error_code, [23] 0
   output logic [2:0]  rsp_tuser    // [2:0] kind
);

   localparam int LB = hrf_pkg::LENGTH_BITS;

   hrf_pkg::phase_type phase_ff, phase_in;
   logic [9:0]    status_ff, status_in;
   logic [2:0]    cand_ff, cand_in;
   logic [4:0]    tpos_ff, tpos_in;
   logic [2:0]    np_ff, np_in;
   logic [LB-1:0] len_ff, len_in;
   logic [LB-1:0] rem_ff, rem_in;
   logic [3:0]    flags_ff, flags_in;
   logic [1:0]    crlf_ff, crlf_in;

   logic          rsp_valid_ff, rsp_valid_in;
   logic [2:0]    rsp_kind_ff, rsp_kind_in;
   logic [22:0]   rsp_data_ff, rsp_data_in;

   logic accept;
   hrf_pkg::kind_type res_kind;
   hrf_pkg::err_type  res_err;
   logic [7:0]  res_byte;
   logic [7:0]  b, c;
   logic [3:0]  hexv;
   logic        hex_ok, digit_ok, chunk, live;
   logic [LB+3:0] dec_acc, hex_acc;
   logic        dec_ovf, hex_ovf;
   logic        go_next_line, go_header_end;
   logic [1:0]  hit;

   assign accept     = req_tvalid && req_tready;
   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign b          = req_tdata;
   assign c          = hrf_pkg::lower(req_tdata);

   // digit decode and overflow-checked accumulators
   always_comb begin
      digit_ok = (b >= 8'h30) && (b <= 8'h39);
      hex_ok   = 1'b1;
      hexv     = 4'd0;
      if (digit_ok) hexv = 4'(b - 8'h30);
      else if (c >= 8'h61 && c <= 8'h66) hexv = 4'(c - 8'h57);
      else hex_ok = 1'b0;
      dec_acc = ({4'd0, len_ff} << 3) + ({4'd0, len_ff} << 1) + (LB+4)'(hexv);
      dec_ovf = dec_acc[LB+3:LB] != 4'd0;
      hex_acc = {rem_ff, hexv};
      hex_ovf = rem_ff[LB-1:LB-4] != 4'd0;
   end

   // next parser state and result
   always_comb begin
      phase_in = phase_ff; status_in = status_ff; cand_in = cand_ff; tpos_in = tpos_ff;
      np_in = np_ff; len_in = len_ff; rem_in = rem_ff; flags_in = flags_ff; crlf_in = crlf_ff;
      res_kind = hrf_pkg::KIND_NOTHING; res_err = hrf_pkg::ERR_NONE; res_byte = 8'd0;
      go_next_line = 1'b0; go_header_end = 1'b0;
      chunk = cand_ff[1];
      hit = 2'd3;

      case (hrf_pkg::action_type'(req_tuser))
         hrf_pkg::ACT_RESTART: begin
            phase_in = hrf_pkg::PH_VERSION; status_in = 10'd0; cand_in = 3'd7;
            tpos_in = 5'd0; np_in = 3'd0; len_in = '0; rem_in = '0;
            flags_in = 4'd0; crlf_in = 2'd0;
         end
         hrf_pkg::ACT_CLOSED: begin
            if (phase_ff <= hrf_pkg::PH_SKIP) begin
               res_kind = hrf_pkg::KIND_ERROR; res_err = hrf_pkg::ERR_CLOSED_HEADER;
            end else if (phase_ff == hrf_pkg::PH_BODY_CLOSE) begin
               flags_in[hrf_pkg::FL_PEER] = 1'b1;
               phase_in = hrf_pkg::PH_DONE;
               res_kind = hrf_pkg::KIND_COMPLETE;
            end else if (phase_ff != hrf_pkg::PH_DONE && phase_ff != hrf_pkg::PH_FAILED) begin
               res_kind = hrf_pkg::KIND_ERROR; res_err = hrf_pkg::ERR_CLOSED_BODY;
            end
         end
         hrf_pkg::ACT_DATA: begin
            if (phase_ff <= hrf_pkg::PH_SKIP) begin
               // header section
               if (crlf_ff >= 2'd2) begin
                  if (b != 8'h0A) begin
                     res_kind = hrf_pkg::KIND_ERROR; res_err = hrf_pkg::ERR_STATUS_LINE;
                  end else begin
                     case (phase_ff)
                        hrf_pkg::PH_VERSION: begin
                           res_kind = hrf_pkg::KIND_ERROR; res_err = hrf_pkg::ERR_STATUS_LINE;
                        end
                        hrf_pkg::PH_CODE: begin
                           if (np_ff == 3'd0) begin
                              res_kind = hrf_pkg::KIND_ERROR; res_err = hrf_pkg::ERR_CODE;
                           end else go_next_line = 1'b1;
                        end
                        hrf_pkg::PH_KEY: begin
                           if (crlf_ff == 2'd2) go_header_end = 1'b1;
                           else go_next_line = 1'b1;
                        end
                        hrf_pkg::PH_LEN: begin
                           if (np_ff == 3'd0) begin
                              res_kind = hrf_pkg::KIND_ERROR; res_err = hrf_pkg::ERR_LENGTH;
                           end else begin
                              flags_in[hrf_pkg::FL_LEN] = 1'b1;
                              go_next_line = 1'b1;
                           end
                        end
                        default: go_next_line = 1'b1;
                     endcase
                  end
               end else if (b == 8'h0D) begin
                  crlf_in = (crlf_ff == 2'd0) ? 2'd2 : 2'd3;
               end else begin
                  crlf_in = 2'd1;
                  case (phase_ff)
                     hrf_pkg::PH_VERSION: begin
                        if (b == 8'h20) begin
                           phase_in = hrf_pkg::PH_CODE; np_in = 3'd0; tpos_in = 5'd0;
                        end
                     end
                     hrf_pkg::PH_CODE: begin
                        if (b == 8'h20) begin
                           if (np_ff == 3'd0) begin
                              res_kind = hrf_pkg::KIND_ERROR; res_err = hrf_pkg::ERR_CODE;
                           end else phase_in = hrf_pkg::PH_REASON;
                        end else if (hrf_pkg::is_ws(b)) begin
                           if (np_ff == 3'd1) np_in = 3'd2;
                        end else if (digit_ok && np_ff != 3'd2 && tpos_ff < 5'd3) begin
                           status_in = 10'(status_ff * 10'd10 + 10'(hexv));
                           tpos_in = tpos_ff + 5'd1;
                           np_in = 3'd1;
                        end else begin
                           res_kind = hrf_pkg::KIND_ERROR; res_err = hrf_pkg::ERR_CODE;
                        end
                     end
                     hrf_pkg::PH_KEY: begin
                        if (b == 8'h3A) begin
                           if (cand_ff[0] && tpos_ff == hrf_pkg::KEY_LEN_SIZE) hit = 2'd0;
                           if (cand_ff[1] && tpos_ff == hrf_pkg::KEY_TE_SIZE) hit = 2'd1;
                           if (cand_ff[2] && tpos_ff == hrf_pkg::KEY_CONN_SIZE) hit = 2'd2;
                           np_in = 3'd0;
                           if (hit == 2'd0) begin
                              len_in = '0; phase_in = hrf_pkg::PH_LEN;
                           end else if (hit != 2'd3) begin
                              cand_in = 3'(3'd1 << hit); phase_in = hrf_pkg::PH_SCAN;
                           end else phase_in = hrf_pkg::PH_SKIP;
                        end else if (hrf_pkg::is_ws(b)) begin
                           if (tpos_ff != 5'd0) np_in = 3'd1;
                        end else if (np_ff == 3'd1) begin
                           cand_in = 3'd0;
                        end else begin
                           // drop keys that no longer match
                           for (int k = 0; k < 3; k++)
                              if (c != hrf_pkg::key_char(2'(k), tpos_ff) ||
                                  hrf_pkg::key_char(2'(k), tpos_ff) == 8'h00)
                                 cand_in[k] = 1'b0;
                           if (tpos_ff < 5'd31) tpos_in = tpos_ff + 5'd1;
                        end
                     end
                     hrf_pkg::PH_LEN: begin
                        if (hrf_pkg::is_ws(b)) begin
                           if (np_ff == 3'd1) np_in = 3'd2;
                        end else if (digit_ok && np_ff < 3'd2 && !dec_ovf) begin
                           len_in = dec_acc[LB-1:0]; np_in = 3'd1;
                        end else begin
                           res_kind = hrf_pkg::KIND_ERROR; res_err = hrf_pkg::ERR_LENGTH;
                        end
                     end
                     hrf_pkg::PH_SCAN: begin
                        if (c == hrf_pkg::needle_char(chunk, np_ff)
                            && hrf_pkg::needle_char(chunk, np_ff) != 8'h00) begin
                           np_in = np_ff + 3'd1;
                           if (np_ff + 3'd1 == (chunk ? 3'd7 : 3'd5)) begin
                              if (chunk) flags_in[hrf_pkg::FL_CHUNKED] = 1'b1;
                              else flags_in[hrf_pkg::FL_CLOSE] = 1'b1;
                              np_in = 3'd0;
                           end
                        end else np_in = (c == 8'h63) ? 3'd1 : 3'd0;
                     end
                     default: ;
                  endcase
               end
            end else begin
               // body section
               case (phase_ff)
                  hrf_pkg::PH_BODY_LEN: begin
                     rem_in = rem_ff - LB'(1);
                     res_byte = b;
                     if (rem_ff == LB'(1)) begin
                        phase_in = hrf_pkg::PH_DONE; res_kind = hrf_pkg::KIND_COMPLETE;
                     end else res_kind = hrf_pkg::KIND_BODY;
                  end
                  hrf_pkg::PH_BODY_CLOSE: begin
                     res_byte = b; res_kind = hrf_pkg::KIND_BODY;
                  end
                  hrf_pkg::PH_CHUNK_SIZE: begin
                     if (crlf_ff != 2'd0) begin
                        crlf_in = 2'd0;
                        if (b != 8'h0A || np_ff == 3'd0 || np_ff == 3'd3) begin
                           res_kind = hrf_pkg::KIND_ERROR; res_err = hrf_pkg::ERR_CHUNK_LINE;
                        end else begin
                           np_in = 3'd0;
                           phase_in = (rem_ff == '0) ? hrf_pkg::PH_TRAILER
                                                     : hrf_pkg::PH_CHUNK_DATA;
                        end
                     end else if (b == 8'h0D) begin
                        crlf_in = 2'd1;
                     end else if (np_ff >= 3'd3) begin
                        // skip chunk extension
                     end else if (hrf_pkg::is_ws(b)) begin
                        if (np_ff == 3'd1) np_in = 3'd2;
                     end else if (b == 8'h3B) begin
                        np_in = (np_ff == 3'd0) ? 3'd3 : 3'd4;
                     end else if (!hex_ok || np_ff == 3'd2 || hex_ovf) begin
                        res_kind = hrf_pkg::KIND_ERROR; res_err = hrf_pkg::ERR_CHUNK_SIZE;
                     end else begin
                        rem_in = hex_acc[LB-1:0]; np_in = 3'd1;
                     end
                  end
                  hrf_pkg::PH_CHUNK_DATA: begin
                     rem_in = rem_ff - LB'(1);
                     if (rem_ff == LB'(1)) begin
                        phase_in = hrf_pkg::PH_CHUNK_END; crlf_in = 2'd0;
                     end
                     res_byte = b; res_kind = hrf_pkg::KIND_BODY;
                  end
                  hrf_pkg::PH_CHUNK_END: begin
                     if (crlf_ff == 2'd0) begin
                        if (b != 8'h0D) begin
                           res_kind = hrf_pkg::KIND_ERROR; res_err = hrf_pkg::ERR_MISSING_CRLF;
                        end else crlf_in = 2'd1;
                     end else if (b != 8'h0A) begin
                        res_kind = hrf_pkg::KIND_ERROR; res_err = hrf_pkg::ERR_MISSING_CRLF;
                     end else begin
                        phase_in = hrf_pkg::PH_CHUNK_SIZE; crlf_in = 2'd0;
                        np_in = 3'd0; rem_in = '0;
                     end
                  end
                  hrf_pkg::PH_TRAILER: begin
                     if (crlf_ff >= 2'd2) begin
                        if (b != 8'h0A) begin
                           res_kind = hrf_pkg::KIND_ERROR; res_err = hrf_pkg::ERR_CHUNK_LINE;
                        end else if (crlf_ff == 2'd2) begin
                           phase_in = hrf_pkg::PH_DONE; res_kind = hrf_pkg::KIND_COMPLETE;
                        end else crlf_in = 2'd0;
                     end else if (b == 8'h0D) begin
                        crlf_in = (crlf_ff == 2'd0) ? 2'd2 : 2'd3;
                     end else crlf_in = 2'd1;
                  end
                  default: ;
               endcase
            end
         end
         default: ;
      endcase

      // start the next header line
      if (go_next_line) begin
         phase_in = hrf_pkg::PH_KEY; cand_in = 3'd7; tpos_in = 5'd0;
         np_in = 3'd0; crlf_in = 2'd0;
      end
      // choose body framing at the empty line
      if (go_header_end) begin
         crlf_in = 2'd0; np_in = 3'd0; rem_in = '0;
         if (flags_ff[hrf_pkg::FL_CHUNKED]) begin
            phase_in = hrf_pkg::PH_CHUNK_SIZE; res_kind = hrf_pkg::KIND_HEADER;
         end else if (flags_ff[hrf_pkg::FL_LEN]) begin
            if (len_ff == '0) begin
               phase_in = hrf_pkg::PH_DONE; res_kind = hrf_pkg::KIND_COMPLETE;
            end else begin
               rem_in = len_ff; phase_in = hrf_pkg::PH_BODY_LEN;
               res_kind = hrf_pkg::KIND_HEADER;
            end
         end else if (flags_ff[hrf_pkg::FL_CLOSE]) begin
            phase_in = hrf_pkg::PH_BODY_CLOSE; res_kind = hrf_pkg::KIND_HEADER;
         end else begin
            res_kind = hrf_pkg::KIND_ERROR; res_err = hrf_pkg::ERR_NO_FRAMING;
         end
      end
      if (res_kind == hrf_pkg::KIND_ERROR) phase_in = hrf_pkg::PH_FAILED;
   end

   // pack the result word
   always_comb begin
      live = (res_kind == hrf_pkg::KIND_BODY) || (res_kind == hrf_pkg::KIND_HEADER)
          || (res_kind == hrf_pkg::KIND_COMPLETE);
      rsp_kind_in = res_kind;
      rsp_data_in = {res_err,
                     live && (flags_in[hrf_pkg::FL_CLOSE] || flags_in[hrf_pkg::FL_PEER]),
                     live ? status_in : 10'd0,
                     res_byte};
      rsp_valid_in = accept ? 1'b1 : (rsp_valid_ff && !rsp_tready);
   end

   // advance state on accept, hold the result until taken
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= hrf_pkg::PH_VERSION; status_ff <= 10'd0; cand_ff <= 3'd7;
         tpos_ff <= 5'd0; np_ff <= 3'd0; len_ff <= '0; rem_ff <= '0;
         flags_ff <= 4'd0; crlf_ff <= 2'd0; rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (accept) begin
            phase_ff <= phase_in; status_ff <= status_in; cand_ff <= cand_in;
            tpos_ff <= tpos_in; np_ff <= np_in; len_ff <= len_in; rem_ff <= rem_in;
            flags_ff <= flags_in; crlf_ff <= crlf_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_kind_ff <= rsp_kind_in;
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_kind_ff;
   assign rsp_tdata  = {1'b0, rsp_data_ff};

`ifndef ASSERT_OFF
   // an error word always carries a code, any other word none
   a_err_code: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> ((rsp_tuser == hrf_pkg::KIND_ERROR) == (rsp_tdata[22:19] != 4'd0)))
      else $error("error code does not match result kind");

   // a finished response ignores further data words
   a_done_quiet: assert property (@(posedge clock) disable iff (reset)
      (accept && req_tuser == hrf_pkg::ACT_DATA &&
       (phase_ff == hrf_pkg::PH_DONE || phase_ff == hrf_pkg::PH_FAILED))
      |=> (rsp_tuser == hrf_pkg::KIND_NOTHING))
      else $error("result after completion");

   // input stalls only behind a held result
   a_ready: assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> (rsp_tvalid && !rsp_tready))
      else $error("input stalled without back-pressure");

   // an error always moves the parser to the failed phase
   a_fail: assert property (@(posedge clock) disable iff (reset)
      (accept && res_kind == hrf_pkg::KIND_ERROR) |=> (phase_ff == hrf_pkg::PH_FAILED))
      else $error("error without failed phase");
`endif

endmodule
